// ===== sv/ccbt_pkg.sv =====
package ccbt_pkg;

   localparam int NUM_COEF  = 16;
   localparam int NUM_ROWS  = 4;
   localparam int NUM_CORN  = 8;
   localparam int FIX_SHIFT = 16;

   typedef logic signed [31:0] coef_type;
   typedef logic signed [63:0] prod_type;
   typedef logic signed [67:0] acc_type;
   typedef logic [3:0]         csr_index_type;
   typedef logic [63:0]        csr_data_type;

   localparam csr_index_type NUM_REGS = 4'd8;
   localparam coef_type      FIX_ONE  = 32'sd65536;

   // column-major, coef[col * 4 + row]; identity
   localparam coef_type COEF_RESET [NUM_COEF] = '{
      FIX_ONE, 32'sd0, 32'sd0, 32'sd0,
      32'sd0, FIX_ONE, 32'sd0, 32'sd0,
      32'sd0, 32'sd0, FIX_ONE, 32'sd0,
      32'sd0, 32'sd0, 32'sd0, FIX_ONE
   };

endpackage

// ===== sv/ccbt_corner_cmp.sv =====
module ccbt_corner_cmp (
   input  ccbt_pkg::acc_type acc [ccbt_pkg::NUM_ROWS],
   output logic              outside
);

   ccbt_pkg::acc_type lo_sum [3];
   ccbt_pkg::acc_type hi_dif [3];
   logic [2:0]        lo_out;
   logic [2:0]        hi_out;

   // below -w: c + w < 0 ; above w: c - w > 0 ; equal counts as inside
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         lo_sum[r] = acc[r] + acc[3];
         hi_dif[r] = acc[r] - acc[3];
         lo_out[r] = lo_sum[r][67];
         hi_out[r] = !hi_dif[r][67] && (hi_dif[r] != '0);
      end
      outside = |lo_out || |hi_out;
   end

endmodule

// ===== sv/clip_space_box_corner_test_top.sv =====
// Box-versus-clip-volume test. Each item is an axis-aligned box (min and max
// per axis, signed Q16.16); the eight corners are taken with w = 1, transformed
// by the column-major 4x4 Q16.16 matrix in the eight 64-bit CSRs (identity
// after reset), and rsp_corner_outside is 1 when any corner has x, y or z
// strictly below -w or above w. Arithmetic is exact, no rounding or saturation.
// The pipeline registers the input, the products of 24 parallel 32x32
// multipliers, two adder levels and the compare; one item is taken
// every cycle while the result side does not stall. Matrix writes are taken
// at any time (csr_ready is always high) but should only be made while no
// item is in flight; indexes 8 and up are ignored.
module clip_space_box_corner_test_top (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [31:0]       req_box_max_x,
   input  logic signed [31:0]       req_box_min_x,
   input  logic signed [31:0]       req_box_max_y,
   input  logic signed [31:0]       req_box_min_y,
   input  logic signed [31:0]       req_box_max_z,
   input  logic signed [31:0]       req_box_min_z,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic                     rsp_corner_outside,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  ccbt_pkg::csr_index_type  csr_index,
   input  ccbt_pkg::csr_data_type   csr_data
);

   ccbt_pkg::coef_type coef_ff [ccbt_pkg::NUM_COEF];

   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic rdy1, rdy2, rdy3, rdy4, rdy5;

   // stage 1: box, index 0 = min, 1 = max
   ccbt_pkg::coef_type bx_ff [2];
   ccbt_pkg::coef_type by_ff [2];
   ccbt_pkg::coef_type bz_ff [2];

   // stage 2: products per row and min/max
   ccbt_pkg::prod_type px_ff [ccbt_pkg::NUM_ROWS][2];
   ccbt_pkg::prod_type py_ff [ccbt_pkg::NUM_ROWS][2];
   ccbt_pkg::prod_type pz_ff [ccbt_pkg::NUM_ROWS][2];
   ccbt_pkg::prod_type px_in [ccbt_pkg::NUM_ROWS][2];
   ccbt_pkg::prod_type py_in [ccbt_pkg::NUM_ROWS][2];
   ccbt_pkg::prod_type pz_in [ccbt_pkg::NUM_ROWS][2];

   // stage 3: x+y for four combinations, z+translation for two
   ccbt_pkg::acc_type sxy_ff [ccbt_pkg::NUM_ROWS][4];
   ccbt_pkg::acc_type szt_ff [ccbt_pkg::NUM_ROWS][2];
   ccbt_pkg::acc_type sxy_in [ccbt_pkg::NUM_ROWS][4];
   ccbt_pkg::acc_type szt_in [ccbt_pkg::NUM_ROWS][2];

   // stage 4: full row sums per corner, corner = 4*sx + 2*sy + sz
   ccbt_pkg::acc_type acc_ff [ccbt_pkg::NUM_CORN][ccbt_pkg::NUM_ROWS];
   ccbt_pkg::acc_type acc_in [ccbt_pkg::NUM_CORN][ccbt_pkg::NUM_ROWS];

   logic [ccbt_pkg::NUM_CORN-1:0] corn_out;
   logic                          out_ff;

   // ---------------------------------------------------------------- csr
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ccbt_pkg::NUM_COEF; i++) begin
            coef_ff[i] <= ccbt_pkg::COEF_RESET[i];
         end
      end else if (csr_valid && csr_ready && (csr_index < ccbt_pkg::NUM_REGS)) begin
         coef_ff[{csr_index[2:0], 1'b0}] <= csr_data[31:0];
         coef_ff[{csr_index[2:0], 1'b1}] <= csr_data[63:32];
      end
   end

   // ---------------------------------------------------------------- flow
   assign rdy5      = !v5_ff || !rsp_stall;
   assign rdy4      = !v4_ff || rdy5;
   assign rdy3      = !v3_ff || rdy4;
   assign rdy2      = !v2_ff || rdy3;
   assign rdy1      = !v1_ff || rdy2;
   assign req_stall = !rdy1;
   assign rsp_valid = v5_ff;
   assign rsp_corner_outside = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= req_valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
         if (rdy5) v5_ff <= v4_ff;
      end
   end

   // ---------------------------------------------------------------- stage 1
   always_ff @(posedge clock) begin
      if (rdy1 && req_valid) begin
         bx_ff[0] <= req_box_min_x;
         bx_ff[1] <= req_box_max_x;
         by_ff[0] <= req_box_min_y;
         by_ff[1] <= req_box_max_y;
         bz_ff[0] <= req_box_min_z;
         bz_ff[1] <= req_box_max_z;
      end
   end

   // ---------------------------------------------------------------- stage 2
   always_comb begin
      for (int r = 0; r < ccbt_pkg::NUM_ROWS; r++) begin
         for (int s = 0; s < 2; s++) begin
            px_in[r][s] = coef_ff[r] * bx_ff[s];
            py_in[r][s] = coef_ff[4 + r] * by_ff[s];
            pz_in[r][s] = coef_ff[8 + r] * bz_ff[s];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy2 && v1_ff) begin
         px_ff <= px_in;
         py_ff <= py_in;
         pz_ff <= pz_in;
      end
   end

   // ---------------------------------------------------------------- stage 3
   always_comb begin
      for (int r = 0; r < ccbt_pkg::NUM_ROWS; r++) begin
         for (int i = 0; i < 4; i++) begin
            sxy_in[r][i] = ccbt_pkg::acc_type'(px_ff[r][i / 2])
                         + ccbt_pkg::acc_type'(py_ff[r][i % 2]);
         end
         for (int s = 0; s < 2; s++) begin
            szt_in[r][s] = ccbt_pkg::acc_type'(pz_ff[r][s])
                         + (ccbt_pkg::acc_type'(coef_ff[12 + r]) <<< ccbt_pkg::FIX_SHIFT);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy3 && v2_ff) begin
         sxy_ff <= sxy_in;
         szt_ff <= szt_in;
      end
   end

   // ---------------------------------------------------------------- stage 4
   always_comb begin
      for (int c = 0; c < ccbt_pkg::NUM_CORN; c++) begin
         for (int r = 0; r < ccbt_pkg::NUM_ROWS; r++) begin
            acc_in[c][r] = sxy_ff[r][c / 2] + szt_ff[r][c % 2];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy4 && v3_ff) begin
         acc_ff <= acc_in;
      end
   end

   // ---------------------------------------------------------------- stage 5
   for (genvar c = 0; c < ccbt_pkg::NUM_CORN; c++) begin : g_corner
      ccbt_corner_cmp u_cmp (
         .acc     (acc_ff[c]),
         .outside (corn_out[c])
      );
   end

   always_ff @(posedge clock) begin
      if (rdy5 && v4_ff) begin
         out_ff <= |corn_out;
      end
   end

   // ---------------------------------------------------------------- checks
   a_flow_no_stall: assert property (@(posedge clock) disable iff (reset)
      (!rsp_stall && v1_ff) |=> v2_ff)
      else $error("item lost between stage 1 and stage 2 without stall");

   a_reset_identity: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> (coef_ff[0] == ccbt_pkg::FIX_ONE && coef_ff[15] == ccbt_pkg::FIX_ONE
                        && coef_ff[3] == '0 && coef_ff[12] == '0))
      else $error("matrix not identity after reset");

   a_stage3_hold: assert property (@(posedge clock) disable iff (reset)
      (v3_ff && !rdy4) |=> (v3_ff && $stable(szt_ff[0][0]) && $stable(sxy_ff[3][3])))
      else $error("stage 3 item changed while held");

endmodule
